FILE: rtl/rotary_knob_tick_processor_macros.svh
// ----------------------------------------------------------------------------
// Rotary knob tick processor assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROTARY_KNOB_TICK_PROCESSOR_MACROS_SVH
`define ROTARY_KNOB_TICK_PROCESSOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RKT_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RKT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rkt_pkg.sv
// ----------------------------------------------------------------------------
// Rotary knob tick processor package
// Shared widths, codes and status types.
// ----------------------------------------------------------------------------
package rkt_pkg;

  localparam int CNT_W = 16;
  localparam int CPS_W = 8;

  localparam logic [CPS_W-1:0] CPS_RESET = 8'd2;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  localparam logic [6:0] HOLD_PERIOD = 7'd100;
  localparam logic [6:0] SHORT_MIN   = 7'd10;
  localparam logic [6:0] LONG_MIN    = 7'd30;

  typedef struct packed {
    logic       down;
    logic       short_press;
    logic       long_press;
    logic [3:0] overflows;
  } button_status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: rtl/rkt_channels.sv
// ----------------------------------------------------------------------------
// Rotary knob tick processor channels
// Valid/ready channels for the tick items and the result items.
// ----------------------------------------------------------------------------
interface rkt_tick_if import rkt_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] raw_count;
  logic             button_pressed;

  modport source (output valid, output raw_count, output button_pressed, input ready);
  modport sink   (input valid, input raw_count, input button_pressed, output ready);
endinterface

interface rkt_result_if import rkt_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [CNT_W-1:0] step_velocity;
  logic signed [CNT_W-1:0] step_acceleration;
  logic [1:0]              direction;
  logic                    moved;
  logic                    short_press;
  logic                    long_press;
  logic                    button_down;
  logic [3:0]              hold_overflow_count;

  modport source (
    output valid, output step_velocity, output step_acceleration, output direction,
    output moved, output short_press, output long_press, output button_down,
    output hold_overflow_count, input ready
  );
  modport sink (
    input valid, input step_velocity, input step_acceleration, input direction,
    input moved, input short_press, input long_press, input button_down,
    input hold_overflow_count, output ready
  );
endinterface

FILE: rtl/rotary_knob_tick_processor.sv
// ----------------------------------------------------------------------------
// Rotary knob tick processor
// Per-tick encoder step velocity and button press classification.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : one item per sampling tick, carrying the raw 16-bit encoder
//            counter and the button level.
//   result : one item per tick item: steps, change of steps, direction,
//            moved flag and the button press status after the tick.
//   cfg_we / cfg_wdata : write counts_per_step (0 acts as 1); write only
//            while no item is in flight.
// Flow: the serial divider resolves one quotient bit per cycle; a new tick item
//   is taken only after the previous result is loaded into the output register.
// Reset clears all tracking state and sets counts_per_step to 2; the block
//   is ready for a tick item in the first cycle after reset.
// A stalled receiver holds the result in the output register; a new item is
//   taken meanwhile, and its result waits until the held one is taken.
// ----------------------------------------------------------------------------
`include "rotary_knob_tick_processor_macros.svh"

module rotary_knob_tick_processor import rkt_pkg::*; #(
  parameter int MAX_HOLD_OVERFLOWS = 15
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CPS_W-1:0] cfg_wdata,
  rkt_tick_if.sink         tick,
  rkt_result_if.source     result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_ABS  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]             state;
  logic [CPS_W-1:0]       counts_per_step;
  logic [CNT_W-1:0]       last_count;
  logic signed [CPS_W:0]  step_remainder;
  logic [CNT_W-1:0]       last_velocity;
  logic signed [CNT_W:0]  delta;
  logic signed [CNT_W:0]  sum;
  logic [CPS_W-1:0]       divisor;
  logic signed [CNT_W:0]  steps;

  logic                   accept;
  logic [CNT_W-1:0]       diff16;
  logic signed [CNT_W:0]  delta_next;
  logic [CNT_W-1:0]       magnitude;
  logic                   load_out;

  logic                   div_start;
  div_status_t            div_stat;
  logic [CNT_W-1:0]       div_quot;
  logic [CPS_W-1:0]       div_rem;
  button_status_t         btn;

  assign accept     = tick.valid && tick.ready;
  assign tick.ready = (state == S_IDLE);

  // an exact half-range difference is taken as negative when the new count's top bit is set, else positive
  assign diff16 = tick.raw_count - last_count;
  always_comb begin
    if (diff16 == {1'b1, {(CNT_W-1){1'b0}}}) begin
      delta_next = tick.raw_count[CNT_W-1] ? {2'b11, {(CNT_W-1){1'b0}}}
                                           : {2'b01, {(CNT_W-1){1'b0}}};
    end else begin
      delta_next = {diff16[CNT_W-1], diff16};
    end
  end

  assign magnitude = sum[CNT_W] ? CNT_W'(-sum) : sum[CNT_W-1:0];
  assign div_start = (state == S_ABS);
  assign load_out  = (state == S_DONE) && (!result.valid || result.ready);

  rkt_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (magnitude),
    .divisor   (divisor),
    .status    (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  rkt_button #(
    .MAX_HOLD_OVERFLOWS (MAX_HOLD_OVERFLOWS)
  ) u_button (
    .clk     (clk),
    .rst     (rst),
    .tick    (accept),
    .pressed (tick.button_pressed),
    .status  (btn)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_step <= CPS_RESET;
    end else if (cfg_we) begin
      counts_per_step <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      last_count     <= '0;
      step_remainder <= '0;
      last_velocity  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_count <= tick.raw_count;
            state      <= S_SUM;
          end
        end
        S_SUM: begin
          state <= S_ABS;
        end
        S_ABS: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            // truncate toward zero: remainder takes the sign of the dividend
            step_remainder <= sum[CNT_W] ? (CPS_W+1)'(-{1'b0, div_rem})
                                         : {1'b0, div_rem};
            state          <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            last_velocity <= steps[CNT_W-1:0];
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      delta <= delta_next;
    end
    if (state == S_SUM) begin
      sum     <= {{(CNT_W-CPS_W){step_remainder[CPS_W]}}, step_remainder} + delta;
      divisor <= (counts_per_step == '0) ? CPS_W'(1) : counts_per_step;
    end
    if (state == S_DIV && div_stat.done) begin
      steps <= sum[CNT_W] ? (CNT_W+1)'(-{1'b0, div_quot}) : {1'b0, div_quot};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.step_velocity     <= steps[CNT_W-1:0];
      result.step_acceleration <= steps[CNT_W-1:0] - last_velocity;
      if (steps == '0) begin
        result.direction <= DIR_NONE;
      end else if (steps[CNT_W]) begin
        result.direction <= DIR_CCW;
      end else begin
        result.direction <= DIR_CW;
      end
      result.moved               <= (steps != '0);
      result.short_press         <= btn.short_press;
      result.long_press          <= btn.long_press;
      result.button_down         <= btn.down;
      result.hold_overflow_count <= btn.overflows;
    end
  end

  `RKT_ASSERT_NEXT(a_accept_starts_sum, accept, state == S_SUM, "accepted item did not start")
  `RKT_ASSERT_SAME(a_done_only_in_div, div_stat.done, state == S_DIV, "stray divider done")
  `RKT_ASSERT_SAME(a_rem_below_divisor, div_stat.done, div_rem < divisor, "remainder too big")
  `RKT_ASSERT_SAME(a_moved_matches_dir, result.valid, result.moved == (result.direction != DIR_NONE), "moved and direction disagree")
  `RKT_ASSERT_SAME(a_single_press_kind, result.valid, !(result.short_press && result.long_press), "both press latches set")

endmodule

FILE: rtl/rkt_divider.sv
// ----------------------------------------------------------------------------
// Rotary knob serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rkt_divider import rkt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CNT_W-1:0] dividend,
  input  logic [CPS_W-1:0] divisor,
  output div_status_t      status,
  output logic [CNT_W-1:0] quotient,
  output logic [CPS_W-1:0] remainder
);

  localparam int CW = $clog2(CNT_W + 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] count;

  logic [CNT_W-1:0] quot;
  logic [CPS_W-1:0] rem;
  logic [CPS_W:0]   partial;
  logic [CPS_W:0]   diff;
  logic             ge;

  // shift the next dividend bit into the partial remainder
  assign partial = {rem, quot[CNT_W-1]};
  assign ge      = partial >= {1'b0, divisor};
  assign diff    = partial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(CNT_W);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[CNT_W-2:0], ge};
      rem  <= ge ? diff[CPS_W-1:0] : partial[CPS_W-1:0];
    end
  end

  assign status    = '{busy: busy, done: done};
  assign quotient  = quot;
  assign remainder = rem;

endmodule

FILE: rtl/rkt_button.sv
// ----------------------------------------------------------------------------
// Rotary knob button tracker
// Counts hold ticks and hold periods, latches short and long presses.
// ----------------------------------------------------------------------------
module rkt_button import rkt_pkg::*; #(
  parameter int MAX_HOLD_OVERFLOWS = 15
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           tick,
  input  logic           pressed,
  output button_status_t status
);

  logic       down;
  logic [6:0] hold_ticks;
  logic [3:0] overflows;
  logic       short_latch;
  logic       long_latch;
  logic [6:0] ticks_inc;

  assign ticks_inc = hold_ticks + 7'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      down        <= 1'b0;
      hold_ticks  <= '0;
      overflows   <= '0;
      short_latch <= 1'b0;
      long_latch  <= 1'b0;
    end else if (tick) begin
      if (pressed && !down) begin
        down        <= 1'b1;
        hold_ticks  <= 7'd1;
        overflows   <= '0;
        short_latch <= 1'b0;
        long_latch  <= 1'b0;
      end else if (pressed) begin
        // wrap the tick count once a full hold period has gone by
        if (ticks_inc > HOLD_PERIOD) begin
          hold_ticks <= '0;
          if (overflows < 4'(MAX_HOLD_OVERFLOWS)) begin
            overflows <= overflows + 4'd1;
          end
        end else begin
          hold_ticks <= ticks_inc;
        end
      end else if (down) begin
        if (overflows == 4'd0) begin
          if (hold_ticks >= SHORT_MIN && hold_ticks < LONG_MIN) begin
            short_latch <= 1'b1;
          end else if (hold_ticks >= LONG_MIN && hold_ticks <= HOLD_PERIOD) begin
            long_latch <= 1'b1;
          end
        end
        down       <= 1'b0;
        hold_ticks <= '0;
      end
    end
  end

  assign status = '{down: down, short_press: short_latch, long_press: long_latch,
                    overflows: overflows};

endmodule
